@@ rtl/text_to_page_framebuffer_writer_assert.svh @@
// Assertion macros for the text renderer RTL.
`ifndef TEXT_TO_PAGE_FRAMEBUFFER_WRITER_ASSERT_SVH
`define TEXT_TO_PAGE_FRAMEBUFFER_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TTPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TTPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TTPF_ASSERT(lbl, prop, msg)
`define TTPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ttpf_pkg.sv @@
// Types, constants and the 5x7 glyph table of the text renderer.
package ttpf_pkg;

  localparam int ADDR_W      = 10;
  localparam int GLYPH_IDX_W = 7;
  localparam int COL_IDX_W   = 3;
  localparam int CELL_WIDTH  = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] GLYPH_FIRST    = 8'h20;
  localparam logic [7:0] GLYPH_LAST     = 8'h7E;
  localparam logic [7:0] GLYPH_FALLBACK = 8'h3F;
  localparam logic [7:0] GAP_BYTE       = 8'h00;
  localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(CELL_WIDTH - 1);

  typedef struct packed {
    logic       start_req;
    logic [6:0] start_column;
    logic [2:0] origin_page;
    logic [7:0] char_code;
  } char_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] fb_address;
    logic [7:0]        fb_byte;
    logic              last;
  } wr_word_t;

  typedef struct packed {
    logic [GLYPH_IDX_W-1:0] glyph;
    logic [ADDR_W-1:0]      base;
  } cmd_t;

  // Column 0 of a glyph sits in the top byte.
  function automatic logic [39:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
    logic [39:0] r;
    unique case (idx)
      7'd0:  r = 40'h0000000000;
      7'd1:  r = 40'h00005F0000;
      7'd2:  r = 40'h0007000700;
      7'd3:  r = 40'h147F147F14;
      7'd4:  r = 40'h242A7F2A12;
      7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649552250;
      7'd7:  r = 40'h0005030000;
      7'd8:  r = 40'h001C224100;
      7'd9:  r = 40'h0041221C00;
      7'd10: r = 40'h082A1C2A08;
      7'd11: r = 40'h08083E0808;
      7'd12: r = 40'h0050300000;
      7'd13: r = 40'h0808080808;
      7'd14: r = 40'h0030300000;
      7'd15: r = 40'h2010080402;
      7'd16: r = 40'h3E5149453E;
      7'd17: r = 40'h00427F4000;
      7'd18: r = 40'h4261514946;
      7'd19: r = 40'h2141454B31;
      7'd20: r = 40'h1814127F10;
      7'd21: r = 40'h2745454539;
      7'd22: r = 40'h3C4A494930;
      7'd23: r = 40'h0171090503;
      7'd24: r = 40'h3649494936;
      7'd25: r = 40'h064949291E;
      7'd26: r = 40'h0036360000;
      7'd27: r = 40'h0056360000;
      7'd28: r = 40'h0008142241;
      7'd29: r = 40'h1414141414;
      7'd30: r = 40'h4122140800;
      7'd31: r = 40'h0201510906;
      7'd32: r = 40'h324979413E;
      7'd33: r = 40'h7E1111117E;
      7'd34: r = 40'h7F49494936;
      7'd35: r = 40'h3E41414122;
      7'd36: r = 40'h7F4141221C;
      7'd37: r = 40'h7F49494941;
      7'd38: r = 40'h7F09090901;
      7'd39: r = 40'h3E41415132;
      7'd40: r = 40'h7F0808087F;
      7'd41: r = 40'h00417F4100;
      7'd42: r = 40'h2040413F01;
      7'd43: r = 40'h7F08142241;
      7'd44: r = 40'h7F40404040;
      7'd45: r = 40'h7F0204027F;
      7'd46: r = 40'h7F0408107F;
      7'd47: r = 40'h3E4141413E;
      7'd48: r = 40'h7F09090906;
      7'd49: r = 40'h3E4151215E;
      7'd50: r = 40'h7F09192946;
      7'd51: r = 40'h4649494931;
      7'd52: r = 40'h01017F0101;
      7'd53: r = 40'h3F4040403F;
      7'd54: r = 40'h1F2040201F;
      7'd55: r = 40'h3F4038403F;
      7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0304780403;
      7'd58: r = 40'h6151494543;
      7'd59: r = 40'h00007F4141;
      7'd60: r = 40'h0204081020;
      7'd61: r = 40'h41417F0000;
      7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040;
      7'd64: r = 40'h0001020400;
      7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7F48444438;
      7'd67: r = 40'h3844444420;
      7'd68: r = 40'h384444487F;
      7'd69: r = 40'h3854545418;
      7'd70: r = 40'h087E090102;
      7'd71: r = 40'h081454543C;
      7'd72: r = 40'h7F08040478;
      7'd73: r = 40'h00447D4000;
      7'd74: r = 40'h2040443D00;
      7'd75: r = 40'h007F102844;
      7'd76: r = 40'h00417F4000;
      7'd77: r = 40'h7C04180478;
      7'd78: r = 40'h7C08040478;
      7'd79: r = 40'h3844444438;
      7'd80: r = 40'h7C14141408;
      7'd81: r = 40'h081414187C;
      7'd82: r = 40'h7C08040408;
      7'd83: r = 40'h4854545420;
      7'd84: r = 40'h043F444020;
      7'd85: r = 40'h3C4040207C;
      7'd86: r = 40'h1C2040201C;
      7'd87: r = 40'h3C4030403C;
      7'd88: r = 40'h4428102844;
      7'd89: r = 40'h0C5050503C;
      7'd90: r = 40'h4464544C44;
      7'd91: r = 40'h0008364100;
      7'd92: r = 40'h00007F0000;
      7'd93: r = 40'h0041360800;
      7'd94: r = 40'h08082A1C08;
      default: r = 40'h0000000000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_column(input logic [GLYPH_IDX_W-1:0] idx,
                                              input logic [COL_IDX_W-1:0] k);
    logic [39:0] bits;
    logic [7:0]  col;
    bits = glyph_bits(idx);
    unique case (k)
      3'd0:    col = bits[39:32];
      3'd1:    col = bits[31:24];
      3'd2:    col = bits[23:16];
      3'd3:    col = bits[15:8];
      3'd4:    col = bits[7:0];
      default: col = GAP_BYTE;
    endcase
    return col;
  endfunction

endpackage

@@ rtl/text_to_page_framebuffer_writer.sv @@
// Top level of the 5x7 text renderer for a page-organized framebuffer.
//   channel  direction  word         handshake
//   char     in         char_word_t  char_valid / char_stall
//   wr       out        wr_word_t    wr_valid / wr_stall
// A drawn character makes 6 byte writes at the write port, one per cycle while wr_stall is low.
// A character that is dropped past the last page is accepted but makes no writes.
// The front accepts one character per cycle until the 2-entry command queue fills.
// Reset is synchronous; it puts the cursor at column 0, page 0 and empties the queue.
// wr_stall holds the current write; the queue and front keep taking characters meanwhile until the queue fills.
module text_to_page_framebuffer_writer #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  ttpf_pkg::char_word_t char_word,
  output logic                 wr_valid,
  input  logic                 wr_stall,
  output ttpf_pkg::wr_word_t   wr_word
);

  logic           q_full, q_push, q_pop, q_nonempty;
  ttpf_pkg::cmd_t q_cmd, q_head;

  ttpf_front #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word (char_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  ttpf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .head    (q_head)
  );

  ttpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_nonempty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .wr_valid(wr_valid),
    .wr_stall(wr_stall),
    .wr_word (wr_word)
  );

endmodule

@@ rtl/ttpf_front.sv @@
// Front end: cursor tracking, wrap and drop decisions, glyph lookup index.
module ttpf_front #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int PAGE_COUNT    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  ttpf_pkg::char_word_t char_word,
  input  logic                q_full,
  output logic                q_push,
  output ttpf_pkg::cmd_t      q_cmd
);

  localparam int CW = ($clog2(DISPLAY_WIDTH + 1) > 7) ? $clog2(DISPLAY_WIDTH + 1) : 7;
  localparam int PW = ($clog2(PAGE_COUNT + 1) > 3) ? $clog2(PAGE_COUNT + 1) : 3;

  logic [CW-1:0] cursor_column, cursor_column_next;
  logic [PW-1:0] cursor_page, cursor_page_next;
  logic [CW-1:0] col_eff, draw_col;
  logic [PW-1:0] page_eff, page_wrap, draw_page;
  logic          accept, drop, wrap, off_bottom;
  logic [7:0]    code;

  assign accept     = char_valid && !q_full;
  assign char_stall = q_full;

  always_comb begin
    if (char_word.start_req) begin
      col_eff  = CW'(char_word.start_column);
      page_eff = PW'(char_word.origin_page);
    end else begin
      col_eff  = cursor_column;
      page_eff = cursor_page;
    end
    drop       = page_eff >= PW'(PAGE_COUNT);
    wrap       = ((CW + 1)'(col_eff) + (CW + 1)'(ttpf_pkg::CELL_WIDTH))
                 > (CW + 1)'(DISPLAY_WIDTH);
    page_wrap  = page_eff + PW'(1);
    off_bottom = page_wrap >= PW'(PAGE_COUNT);
    draw_col   = wrap ? '0 : col_eff;
    draw_page  = wrap ? page_wrap : page_eff;
    priority if (drop) begin
      cursor_column_next = col_eff;
      cursor_page_next   = page_eff;
    end else if (wrap && off_bottom) begin
      cursor_column_next = CW'(ttpf_pkg::CELL_WIDTH);
      cursor_page_next   = PW'(PAGE_COUNT);
    end else begin
      cursor_column_next = draw_col + CW'(ttpf_pkg::CELL_WIDTH);
      cursor_page_next   = draw_page;
    end
  end

  always_comb begin
    code = char_word.char_code;
    if (code < ttpf_pkg::GLYPH_FIRST || code > ttpf_pkg::GLYPH_LAST) begin
      code = ttpf_pkg::GLYPH_FALLBACK;
    end
    q_cmd.glyph = ttpf_pkg::GLYPH_IDX_W'(code - ttpf_pkg::GLYPH_FIRST);
    q_cmd.base  = ttpf_pkg::ADDR_W'(32'(draw_page) * 32'(DISPLAY_WIDTH) + 32'(draw_col));
  end

  assign q_push = accept && !drop && !(wrap && off_bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_page   <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_page   <= cursor_page_next;
    end
  end

endmodule

@@ rtl/ttpf_queue.sv @@
// Short command queue between the front end and the write sequencer.
module ttpf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ttpf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output ttpf_pkg::cmd_t head
);

  ttpf_pkg::cmd_t                  entries [ttpf_pkg::QUEUE_DEPTH];
  logic [ttpf_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [ttpf_pkg::QCNT_W-1:0]     count;

  function automatic logic [ttpf_pkg::QPTR_W-1:0] bump(input logic [ttpf_pkg::QPTR_W-1:0] p);
    return (p == ttpf_pkg::QPTR_W'(ttpf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = count == ttpf_pkg::QCNT_W'(ttpf_pkg::QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ttpf_back.sv @@
// Write sequencer: six framebuffer byte writes per queued character.
`include "text_to_page_framebuffer_writer_assert.svh"
module ttpf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ttpf_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               wr_valid,
  input  logic               wr_stall,
  output ttpf_pkg::wr_word_t wr_word
);

  ttpf_pkg::cmd_t                 cmd, src;
  logic                           busy;
  logic [ttpf_pkg::COL_IDX_W-1:0] cnt, k;
  logic                           advance, emit;

  assign advance = !wr_valid || !wr_stall;
  assign emit    = advance && (busy || q_valid);
  assign q_pop   = advance && !busy && q_valid;
  assign src     = busy ? cmd : q_head;
  assign k       = busy ? cnt : '0;

  always_ff @(posedge clk) begin
    if (emit) begin
      wr_word.fb_address <= src.base + ttpf_pkg::ADDR_W'(k);
      wr_word.fb_byte    <= ttpf_pkg::glyph_column(src.glyph, k);
      wr_word.last       <= k == ttpf_pkg::LAST_COL;
    end
    if (q_pop) begin
      cmd <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      wr_valid <= 1'b0;
    end else if (advance) begin
      wr_valid <= busy || q_valid;
      if (busy) begin
        if (cnt == ttpf_pkg::LAST_COL) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else if (q_valid) begin
        busy <= 1'b1;
        cnt  <= ttpf_pkg::COL_IDX_W'(1);
      end
    end
  end

  `TTPF_ASSERT(a_gap_blank, !(wr_valid && wr_word.last) || wr_word.fb_byte == ttpf_pkg::GAP_BYTE, "gap write not blank")
  `TTPF_ASSERT(a_cnt_range, !busy || (cnt != '0 && cnt <= ttpf_pkg::LAST_COL), "column count out of range")
  `TTPF_ASSERT_NEXT(a_char_cont, wr_valid && !wr_stall && !wr_word.last, wr_valid, "character writes broken off")

endmodule
